/* rtl/gpdd_pkg.sv */
package gpdd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DUTY_BITS = 8;
    localparam int MAG_W     = FRAC_BITS + 1;
    localparam int SUM_W     = MAG_W + 1;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int CNT_W     = $clog2(MAG_W + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 17;

    localparam logic [MAG_W-1:0]     ONE          = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [DUTY_BITS-1:0] DUTY_MAX     = {DUTY_BITS{1'b1}};
    localparam logic [15:0]          STICK_CENTER = 16'h8000;
    localparam logic [SUM_W-1:0]     TRIG_FULL    = SUM_W'(1023);

    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPO_WEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY    = 3'd3;

    localparam logic [14:0]          DEAD_BAND_RST   = 15'd655;
    localparam logic [MAG_W-1:0]     EXPO_WEIGHT_RST = 17'd39322;
    localparam logic [MAG_W-1:0]     SPEED_SCALE_RST = 17'd52429;
    localparam logic [DUTY_BITS-1:0] MIN_DUTY_RST    = 8'd60;

    typedef struct packed {
        logic [14:0]          dead_band;
        logic [MAG_W-1:0]     expo_weight;
        logic [MAG_W-1:0]     speed_scale;
        logic [DUTY_BITS-1:0] min_duty;
    } gpdd_cfg_t;

    typedef struct packed {
        logic [15:0] h;
        logic [15:0] v;
        logic [9:0]  t;
        logic        enabled;
        logic        drive_flip;
        logic        weapon_flip;
    } gpdd_job_t;

    typedef struct packed {
        logic                 weapon_flip;
        logic                 drive_flip;
        logic                 enabled;
        logic [DUTY_BITS-1:0] weapon_rev;
        logic [DUTY_BITS-1:0] weapon_fwd;
        logic [DUTY_BITS-1:0] right_rev;
        logic [DUTY_BITS-1:0] right_fwd;
        logic [DUTY_BITS-1:0] left_rev;
        logic [DUTY_BITS-1:0] left_fwd;
    } gpdd_res_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_AXIS,
        S_AX_DIV,
        S_AX_SQ,
        S_AX_CUBE,
        S_AX_P1,
        S_AX_P2,
        S_MIX,
        S_NORM_L,
        S_NORM_R,
        S_SPD_L,
        S_SPD_R,
        S_WPN,
        S_DUTY_L,
        S_DUTY_R,
        S_DUTY_W,
        S_DONE
    } gpdd_state_t;

endpackage

/* rtl/gpdd_mul.sv */
module gpdd_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [gpdd_pkg::MAG_W-1:0] a,
    input  logic [gpdd_pkg::MAG_W-1:0] b,
    output logic                       done,
    output logic [gpdd_pkg::PROD_W-1:0] prod
);
    import gpdd_pkg::*;

    // The upper half accumulates; one multiplier bit is consumed per cycle.
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PROD_W:0]   acc_reg;
    logic [PROD_W:0]   acc_next;
    logic [MAG_W-1:0]  a_reg;
    logic [SUM_W-1:0]  hi_sum;

    always_comb
    begin
        hi_sum   = acc_reg[PROD_W:MAG_W] + (acc_reg[0] ? {1'b0, a_reg} : '0);
        acc_next = {1'b0, hi_sum, acc_reg[MAG_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAG_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= {{SUM_W{1'b0}}, b};
            a_reg   <= a;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg[PROD_W-1:0];

endmodule

/* rtl/gpdd_div.sv */
module gpdd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gpdd_pkg::PROD_W-1:0] num,
    input  logic [gpdd_pkg::SUM_W-1:0]  den,
    output logic                        done,
    output logic [gpdd_pkg::MAG_W-1:0]  quo
);
    import gpdd_pkg::*;

    // Restoring division, one quotient bit per cycle. The quotient always fits
    // in MAG_W bits, so the upper numerator bits seed the remainder directly.
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  rem_next;
    logic [MAG_W-1:0]  q_reg;
    logic [MAG_W-1:0]  q_next;
    logic [SUM_W-1:0]  den_reg;
    logic [SUM_W:0]    trial;
    logic              ge;

    always_comb
    begin
        trial    = {rem_reg, q_reg[MAG_W-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? SUM_W'(trial - {1'b0, den_reg}) : trial[SUM_W-1:0];
        q_next   = {q_reg[MAG_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAG_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num[PROD_W-1:MAG_W]};
            q_reg   <= num[MAG_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

/* rtl/gpdd_seq.sv */
module gpdd_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  gpdd_pkg::gpdd_job_t  job,
    input  gpdd_pkg::gpdd_cfg_t  cfg,
    output logic                 idle,
    output logic                 res_valid,
    input  logic                 res_ack,
    output gpdd_pkg::gpdd_res_t  res
);
    import gpdd_pkg::*;

    gpdd_state_t state_reg, state_next;
    logic        wait_reg, wait_next;
    logic        axis_y_reg, axis_y_next;
    gpdd_job_t   job_reg, job_next;
    gpdd_res_t   res_reg, res_next;
    logic [MAG_W-1:0]  xm_reg, xm_next, ym_reg, ym_next;
    logic [MAG_W-1:0]  r_reg, r_next, tmp_reg, tmp_next, wm_reg, wm_next;
    logic [PROD_W-1:0] p1_reg, p1_next;
    logic [SUM_W-1:0]  lm_reg, lm_next, rm_reg, rm_next, mx_reg, mx_next;
    logic              lneg_reg, lneg_next, rneg_reg, rneg_next;

    logic              mul_start, mul_done, div_start, div_done;
    logic [MAG_W-1:0]  mul_a, mul_b, div_quo;
    logic [PROD_W-1:0] mul_prod, div_num;
    logic [SUM_W-1:0]  div_den;

    logic [15:0]       h_offs, v_offs;
    logic              x_neg, y_neg, below;
    logic [MAG_W-1:0]  mag, dz, one_minus_w, e_val, prod_hi, duty_mag;
    logic [PROD_W-1:0] e_sum;
    logic signed [SUM_W:0] xs, ys, l_sum, r_sum;
    logic [SUM_W-1:0]  l_abs, r_abs;
    logic [DUTY_BITS-1:0] duty_span, pwm, duty_fwd, duty_rev;
    logic              duty_neg;

    gpdd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    gpdd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign x_neg  = ~job_reg.h[15];
    assign h_offs = x_neg ? (STICK_CENTER - job_reg.h) : (job_reg.h - STICK_CENTER);
    assign y_neg  = job_reg.v[15] & (|job_reg.v[14:0]);
    assign v_offs = y_neg ? (job_reg.v - STICK_CENTER) : (STICK_CENTER - job_reg.v);
    assign mag    = {(axis_y_reg ? v_offs : h_offs), 1'b0};
    assign dz     = {2'b00, cfg.dead_band};
    assign below  = mag < dz;
    assign one_minus_w = ONE - cfg.expo_weight;

    assign prod_hi = mul_prod[FRAC_BITS+MAG_W-1:FRAC_BITS];
    assign e_sum   = p1_reg + mul_prod;
    assign e_val   = e_sum[FRAC_BITS+MAG_W-1:FRAC_BITS];

    assign xs    = x_neg ? -$signed({2'b00, xm_reg}) : $signed({2'b00, xm_reg});
    assign ys    = y_neg ? -$signed({2'b00, ym_reg}) : $signed({2'b00, ym_reg});
    assign l_sum = ys + xs;
    assign r_sum = ys - xs;
    assign l_abs = l_sum[SUM_W] ? SUM_W'(-l_sum) : l_sum[SUM_W-1:0];
    assign r_abs = r_sum[SUM_W] ? SUM_W'(-r_sum) : r_sum[SUM_W-1:0];

    assign duty_span = DUTY_MAX - cfg.min_duty;
    assign pwm       = prod_hi[DUTY_BITS-1:0] + cfg.min_duty;

    always_comb
    begin
        case (state_reg)
            S_DUTY_L:
            begin
                duty_mag = lm_reg[MAG_W-1:0];
                duty_neg = lneg_reg ^ job_reg.drive_flip;
            end
            S_DUTY_R:
            begin
                duty_mag = rm_reg[MAG_W-1:0];
                duty_neg = rneg_reg ^ job_reg.drive_flip;
            end
            default:
            begin
                duty_mag = wm_reg;
                duty_neg = job_reg.weapon_flip;
            end
        endcase
        duty_fwd = (duty_mag != '0 && !duty_neg) ? pwm : '0;
        duty_rev = (duty_mag != '0 && duty_neg) ? pwm : '0;
    end

    always_comb
    begin
        state_next  = state_reg;
        wait_next   = wait_reg;
        axis_y_next = axis_y_reg;
        job_next    = job_reg;
        res_next    = res_reg;
        xm_next     = xm_reg;
        ym_next     = ym_reg;
        r_next      = r_reg;
        tmp_next    = tmp_reg;
        wm_next     = wm_reg;
        p1_next     = p1_reg;
        lm_next     = lm_reg;
        rm_next     = rm_reg;
        mx_next     = mx_reg;
        lneg_next   = lneg_reg;
        rneg_next   = rneg_reg;
        mul_start   = 1'b0;
        div_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        div_num     = '0;
        div_den     = TRIG_FULL;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    job_next             = job;
                    res_next             = '0;
                    res_next.enabled     = job.enabled;
                    res_next.drive_flip  = job.drive_flip;
                    res_next.weapon_flip = job.weapon_flip;
                    axis_y_next          = 1'b0;
                    state_next           = job.enabled ? S_AXIS : S_DONE;
                end
            end
            S_AXIS:
            begin
                if (below)
                begin
                    if (axis_y_reg)
                    begin
                        ym_next    = '0;
                        state_next = S_MIX;
                    end
                    else
                    begin
                        xm_next     = '0;
                        axis_y_next = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_AX_DIV;
                end
            end
            S_AX_DIV:
            begin
                div_num = {1'b0, mag - dz, {FRAC_BITS{1'b0}}};
                div_den = {1'b0, ONE} - {3'b000, cfg.dead_band};
                if (!wait_reg)
                begin
                    div_start = 1'b1;
                    wait_next = 1'b1;
                end
                else if (div_done)
                begin
                    r_next     = div_quo;
                    wait_next  = 1'b0;
                    state_next = S_AX_SQ;
                end
            end
            S_AX_SQ, S_AX_CUBE, S_AX_P1, S_AX_P2, S_SPD_L, S_SPD_R,
            S_DUTY_L, S_DUTY_R, S_DUTY_W:
            begin
                case (state_reg)
                    S_AX_SQ:
                    begin
                        mul_a = r_reg;
                        mul_b = r_reg;
                    end
                    S_AX_CUBE:
                    begin
                        mul_a = tmp_reg;
                        mul_b = r_reg;
                    end
                    S_AX_P1:
                    begin
                        mul_a = one_minus_w;
                        mul_b = r_reg;
                    end
                    S_AX_P2:
                    begin
                        mul_a = cfg.expo_weight;
                        mul_b = tmp_reg;
                    end
                    S_SPD_L:
                    begin
                        mul_a = lm_reg[MAG_W-1:0];
                        mul_b = cfg.speed_scale;
                    end
                    S_SPD_R:
                    begin
                        mul_a = rm_reg[MAG_W-1:0];
                        mul_b = cfg.speed_scale;
                    end
                    default:
                    begin
                        mul_a = {{(MAG_W-DUTY_BITS){1'b0}}, duty_span};
                        mul_b = duty_mag;
                    end
                endcase
                if (!wait_reg)
                begin
                    mul_start = 1'b1;
                    wait_next = 1'b1;
                end
                else if (mul_done)
                begin
                    wait_next = 1'b0;
                    case (state_reg)
                        S_AX_SQ:
                        begin
                            tmp_next   = prod_hi;
                            state_next = S_AX_CUBE;
                        end
                        S_AX_CUBE:
                        begin
                            tmp_next   = prod_hi;
                            state_next = S_AX_P1;
                        end
                        S_AX_P1:
                        begin
                            p1_next    = mul_prod;
                            state_next = S_AX_P2;
                        end
                        S_AX_P2:
                        begin
                            if (axis_y_reg)
                            begin
                                ym_next    = e_val;
                                state_next = S_MIX;
                            end
                            else
                            begin
                                xm_next     = e_val;
                                axis_y_next = 1'b1;
                                state_next  = S_AXIS;
                            end
                        end
                        S_SPD_L:
                        begin
                            lm_next    = {1'b0, prod_hi};
                            state_next = S_SPD_R;
                        end
                        S_SPD_R:
                        begin
                            rm_next    = {1'b0, prod_hi};
                            state_next = S_WPN;
                        end
                        S_DUTY_L:
                        begin
                            res_next.left_fwd = duty_fwd;
                            res_next.left_rev = duty_rev;
                            state_next        = S_DUTY_R;
                        end
                        S_DUTY_R:
                        begin
                            res_next.right_fwd = duty_fwd;
                            res_next.right_rev = duty_rev;
                            state_next         = S_DUTY_W;
                        end
                        default:
                        begin
                            res_next.weapon_fwd = duty_fwd;
                            res_next.weapon_rev = duty_rev;
                            state_next          = S_DONE;
                        end
                    endcase
                end
            end
            S_MIX:
            begin
                lm_next    = l_abs;
                rm_next    = r_abs;
                lneg_next  = l_sum[SUM_W];
                rneg_next  = r_sum[SUM_W];
                mx_next    = (l_abs > r_abs) ? l_abs : r_abs;
                state_next = ((l_abs > r_abs ? l_abs : r_abs) > {1'b0, ONE}) ? S_NORM_L
                                                                              : S_SPD_L;
            end
            S_NORM_L, S_NORM_R, S_WPN:
            begin
                case (state_reg)
                    S_NORM_L:
                    begin
                        div_num = {lm_reg, {FRAC_BITS{1'b0}}};
                        div_den = mx_reg;
                    end
                    S_NORM_R:
                    begin
                        div_num = {rm_reg, {FRAC_BITS{1'b0}}};
                        div_den = mx_reg;
                    end
                    default:
                    begin
                        div_num = {{(PROD_W-FRAC_BITS-10){1'b0}}, job_reg.t,
                                   {FRAC_BITS{1'b0}}};
                        div_den = TRIG_FULL;
                    end
                endcase
                if (!wait_reg)
                begin
                    div_start = 1'b1;
                    wait_next = 1'b1;
                end
                else if (div_done)
                begin
                    wait_next = 1'b0;
                    case (state_reg)
                        S_NORM_L:
                        begin
                            lm_next    = {1'b0, div_quo};
                            state_next = S_NORM_R;
                        end
                        S_NORM_R:
                        begin
                            rm_next    = {1'b0, div_quo};
                            state_next = S_SPD_L;
                        end
                        default:
                        begin
                            wm_next    = div_quo;
                            state_next = S_DUTY_L;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (res_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        axis_y_reg <= axis_y_next;
        job_reg    <= job_next;
        res_reg    <= res_next;
        xm_reg     <= xm_next;
        ym_reg     <= ym_next;
        r_reg      <= r_next;
        tmp_reg    <= tmp_next;
        wm_reg     <= wm_next;
        p1_reg     <= p1_next;
        lm_reg     <= lm_next;
        rm_reg     <= rm_next;
        mx_reg     <= mx_next;
        lneg_reg   <= lneg_next;
        rneg_reg   <= rneg_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

/* rtl/gamepad_to_differential_drive.sv */
// Each gamepad request yields one result holding six 8-bit duties and three
// status flags. With the robot enabled a request is worked through by one
// shared bit-serial multiplier and one bit-serial divider, with up to
// eighteen operations run in turn; two of these are divisions that run only
// when the mixed speeds must be normalized. While disabled a request finishes
// with all duties zero. A new request is taken as soon as the sequencer is
// free, even while the previous result still waits on the output.
module gamepad_to_differential_drive (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // stick_horizontal, stick_vertical, trigger_level, bumper_left,
    // bumper_right, start_button, select_button, zero fill
    input  logic [47:0]                    s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // left_fwd_duty, left_rev_duty, right_fwd_duty, right_rev_duty,
    // weapon_fwd_duty, weapon_rev_duty, is_enabled, drive_flipped,
    // weapon_flipped, zero fill
    output logic [55:0]                    m_axis_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gpdd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gpdd_pkg::CFG_DAT_W-1:0] cfg_data
);
    import gpdd_pkg::*;

    gpdd_cfg_t cfg_reg;
    logic      enabled_reg, pending_reg, drive_rev_reg, weapon_rev_reg;
    logic      start_last_reg, select_last_reg;
    logic      enabled_next, pending_next, drive_rev_next, weapon_rev_next;
    logic      out_valid_reg, out_valid_next;
    gpdd_res_t out_res_reg;
    gpdd_res_t seq_res;
    gpdd_job_t job;
    logic      seq_idle, seq_valid, take, in_acc;
    logic      lb, rb, st, se;
    logic [CFG_DAT_W-1:0] sat_data;

    assign lb     = s_axis_tdata[42];
    assign rb     = s_axis_tdata[43];
    assign st     = s_axis_tdata[44];
    assign se     = s_axis_tdata[45];
    assign in_acc = s_axis_tvalid & s_axis_tready;

    always_comb
    begin
        pending_next    = pending_reg | (lb & rb);
        enabled_next    = enabled_reg;
        if (pending_next && !lb && !rb)
        begin
            enabled_next = ~enabled_reg;
            pending_next = 1'b0;
        end
        drive_rev_next  = drive_rev_reg ^ (st & ~start_last_reg);
        weapon_rev_next = weapon_rev_reg ^ (se & ~select_last_reg);
    end

    assign job.h           = s_axis_tdata[15:0];
    assign job.v           = s_axis_tdata[31:16];
    assign job.t           = s_axis_tdata[41:32];
    assign job.enabled     = enabled_next;
    assign job.drive_flip  = drive_rev_next;
    assign job.weapon_flip = weapon_rev_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg     <= 1'b0;
            pending_reg     <= 1'b0;
            drive_rev_reg   <= 1'b0;
            weapon_rev_reg  <= 1'b0;
            start_last_reg  <= 1'b0;
            select_last_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            enabled_reg     <= enabled_next;
            pending_reg     <= pending_next;
            drive_rev_reg   <= drive_rev_next;
            weapon_rev_reg  <= weapon_rev_next;
            start_last_reg  <= st;
            select_last_reg <= se;
        end
    end

    // Weights above one saturate to one when written.
    assign sat_data  = (cfg_data > ONE) ? ONE : cfg_data;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dead_band   <= DEAD_BAND_RST;
            cfg_reg.expo_weight <= EXPO_WEIGHT_RST;
            cfg_reg.speed_scale <= SPEED_SCALE_RST;
            cfg_reg.min_duty    <= MIN_DUTY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEAD_BAND:   cfg_reg.dead_band   <= cfg_data[14:0];
                REG_EXPO_WEIGHT: cfg_reg.expo_weight <= sat_data;
                REG_SPEED_SCALE: cfg_reg.speed_scale <= sat_data;
                REG_MIN_DUTY:    cfg_reg.min_duty    <= cfg_data[DUTY_BITS-1:0];
                default:         ;
            endcase
        end
    end

    gpdd_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_acc),
        .job       (job),
        .cfg       (cfg_reg),
        .idle      (seq_idle),
        .res_valid (seq_valid),
        .res_ack   (take),
        .res       (seq_res)
    );

    assign s_axis_tready  = seq_idle;
    assign take           = seq_valid & (~out_valid_reg | m_axis_tready);
    assign out_valid_next = take | (out_valid_reg & ~m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_res_reg <= seq_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_res_reg};

`ifndef NO_ASSERTIONS
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("sequencer took a request but stayed idle");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        seq_valid && !take |=> seq_valid)
        else $error("finished result dropped before it was taken");

    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[48] |-> m_axis_tdata[47:0] == 48'd0)
        else $error("nonzero duty while disabled");

    a_one_pin_driven: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'd0 || m_axis_tdata[15:8] == 8'd0))
        else $error("both left motor pins driven");
`endif

endmodule
